// ===== hdl/multilevel_priority_run_queue_macros.svh =====
// Assertion macros used by the run queue port checker.
`ifndef MULTILEVEL_PRIORITY_RUN_QUEUE_MACROS_SVH
`define MULTILEVEL_PRIORITY_RUN_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MPRQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("run queue check failed: same-cycle implication");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MPRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("run queue check failed: next-cycle implication");

`endif

// ===== hdl/mprq_pkg.sv =====
// Package: sizes, types and codes of the multilevel priority run queue.
`default_nettype none

package mprq_pkg;

  localparam int LEVELS      = 4;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int POS_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(SLOTS);

  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ID_BITS-1:0] id_t;

  localparam lvl_t TOP_LVL = lvl_t'(LEVELS - 1);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_BOOST = 2'd2,
    OP_FIND  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_RESULT
  } state_e;

  // Update request to the per-level head/count registers.
  typedef struct packed {
    logic enq;
    logic deq;
    logic boost;
    lvl_t lvl;
  } lvl_cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] thread_id;
    logic [1:0] prio;
    logic [1:0] level;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/mprq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mprq_levels.sv =====
// Per-level FIFO heads, fill counts and boosted-entry counts.
`default_nettype none

module mprq_levels import mprq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lvl_cmd_t cmd_i,
  output pos_t     head_o [LEVELS],
  output cnt_t     cnt_o  [LEVELS],
  output cnt_t     bst_o  [LEVELS],
  output logic     any_o,
  output lvl_t     top_o
);

  pos_t head_q [LEVELS];
  pos_t head_d [LEVELS];
  cnt_t cnt_q  [LEVELS];
  cnt_t cnt_d  [LEVELS];
  // Entries counted from the head whose tag reads as the top level.
  cnt_t bst_q  [LEVELS];
  cnt_t bst_d  [LEVELS];

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_d[l] = head_q[l];
      cnt_d[l]  = cnt_q[l];
      bst_d[l]  = bst_q[l];
      if (cmd_i.boost) begin
        bst_d[l] = cnt_q[l];
      end
      if (cmd_i.enq && (cmd_i.lvl == lvl_t'(l))) begin
        cnt_d[l] = cnt_q[l] + 1'b1;
      end
      if (cmd_i.deq && (cmd_i.lvl == lvl_t'(l))) begin
        head_d[l] = (head_q[l] == pos_t'(LEVEL_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] - 1'b1;
        if (bst_q[l] != '0) begin
          bst_d[l] = bst_q[l] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
        bst_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l] <= head_d[l];
        cnt_q[l]  <= cnt_d[l];
        bst_q[l]  <= bst_d[l];
      end
    end
  end

  // Highest non-empty level: later iterations win.
  always_comb begin
    any_o = 1'b0;
    top_o = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (cnt_q[l] != '0) begin
        any_o = 1'b1;
        top_o = lvl_t'(l);
      end
    end
  end

  assign head_o = head_q;
  assign cnt_o  = cnt_q;
  assign bst_o  = bst_q;

endmodule

`default_nettype wire

// ===== hdl/mprq_seq.sv =====
// Operation sequencer with the shared slot address and id compare unit.
`default_nettype none

module mprq_seq import mprq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  op_e      op_i,
  input  id_t      id_i,
  input  lvl_t     lvl_i,
  output logic     ready_o,
  input  pos_t     head_i [LEVELS],
  input  cnt_t     cnt_i  [LEVELS],
  input  cnt_t     bst_i  [LEVELS],
  input  logic     any_i,
  input  lvl_t     top_i,
  output lvl_cmd_t cmd_o,
  output logic     we_o,
  output addr_t    waddr_o,
  output id_t      wdata_o,
  output logic     re_o,
  output addr_t    raddr_o,
  input  id_t      rdata_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  id_t     id_q, id_d;
  lvl_t    lvl_q, lvl_d;
  result_t res_q, res_d;
  // Scan issue pointer and the read in flight.
  lvl_t    iss_lvl_q, iss_lvl_d;
  cnt_t    iss_k_q, iss_k_d;
  logic    iss_done_q, iss_done_d;
  logic    pv_q, pv_d;
  lvl_t    p_lvl_q, p_lvl_d;
  cnt_t    p_k_q, p_k_d;
  logic    match;
  addr_t   addr;

  function automatic addr_t slot_addr(lvl_t lvl, pos_t head, cnt_t off);
    int pos;
    pos = int'(head) + int'(off);
    if (pos >= LEVEL_DEPTH) begin
      pos = pos - LEVEL_DEPTH;
    end
    return addr_t'(int'(lvl) * LEVEL_DEPTH + pos);
  endfunction

  // Entries before the boosted count carry the top-level tag.
  function automatic logic [1:0] tag_of(lvl_t lvl, cnt_t k, cnt_t bst);
    return (k < bst) ? 2'(TOP_LVL) : 2'(lvl);
  endfunction

  assign match = pv_q && (rdata_i == id_q);

  // Slot address generator, shared by enqueue, dequeue and scan.
  always_comb begin
    unique case (state_q)
      S_EXEC: begin
        if (op_q == OP_ENQ) begin
          addr = slot_addr(lvl_q, head_i[lvl_q], cnt_i[lvl_q]);
        end else begin
          addr = slot_addr(top_i, head_i[top_i], '0);
        end
      end
      default: addr = slot_addr(iss_lvl_q, head_i[iss_lvl_q], iss_k_q);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_q)
          OP_DEQ:  state_d = any_i ? S_RDWAIT : S_RESULT;
          OP_FIND: state_d = S_SCAN;
          default: state_d = S_RESULT;
        endcase
      end
      S_RDWAIT: state_d = S_RESULT;
      S_SCAN: begin
        if (match || (iss_done_q && !pv_q)) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    op_d       = op_q;
    id_d       = id_q;
    lvl_d      = lvl_q;
    res_d      = res_q;
    iss_lvl_d  = iss_lvl_q;
    iss_k_d    = iss_k_q;
    iss_done_d = iss_done_q;
    pv_d       = 1'b0;
    p_lvl_d    = p_lvl_q;
    p_k_d      = p_k_q;
    cmd_o      = '0;
    we_o       = 1'b0;
    re_o       = 1'b0;
    waddr_o    = addr;
    raddr_o    = addr;
    wdata_o    = id_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = op_i;
          id_d  = id_i;
          lvl_d = lvl_i;
        end
      end
      S_EXEC: begin
        res_d.status    = ST_OK;
        res_d.thread_id = '0;
        res_d.prio      = '0;
        res_d.level     = '0;
        unique case (op_q)
          OP_ENQ: begin
            if (cnt_i[lvl_q] == cnt_t'(LEVEL_DEPTH)) begin
              res_d.status = ST_FULL;
            end else begin
              we_o      = 1'b1;
              cmd_o.enq = 1'b1;
              cmd_o.lvl = lvl_q;
            end
          end
          OP_DEQ: begin
            if (any_i) begin
              re_o        = 1'b1;
              cmd_o.deq   = 1'b1;
              cmd_o.lvl   = top_i;
              res_d.prio  = tag_of(top_i, '0, bst_i[top_i]);
              res_d.level = 2'(top_i);
            end else begin
              res_d.status = ST_EMPTY;
            end
          end
          OP_BOOST: cmd_o.boost = 1'b1;
          default: begin
            iss_lvl_d  = '0;
            iss_k_d    = '0;
            iss_done_d = 1'b0;
          end
        endcase
      end
      S_RDWAIT: res_d.thread_id = 8'(rdata_i);
      S_SCAN: begin
        if (!iss_done_q) begin
          if (iss_k_q < cnt_i[iss_lvl_q]) begin
            re_o    = 1'b1;
            pv_d    = 1'b1;
            p_lvl_d = iss_lvl_q;
            p_k_d   = iss_k_q;
            iss_k_d = iss_k_q + 1'b1;
          end else if (iss_lvl_q == TOP_LVL) begin
            iss_done_d = 1'b1;
          end else begin
            iss_lvl_d = iss_lvl_q + 1'b1;
            iss_k_d   = '0;
          end
        end
        if (match) begin
          res_d.thread_id = 8'(rdata_i);
          res_d.prio      = tag_of(p_lvl_q, p_k_q, bst_i[p_lvl_q]);
          res_d.level     = 2'(p_lvl_q);
        end else if (iss_done_q && !pv_q) begin
          res_d.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      iss_done_q <= 1'b0;
      pv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      iss_done_q <= iss_done_d;
      pv_q       <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    lvl_q     <= lvl_d;
    res_q     <= res_d;
    iss_lvl_q <= iss_lvl_d;
    iss_k_q   <= iss_k_d;
    p_lvl_q   <= p_lvl_d;
    p_k_q     <= p_k_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/multilevel_priority_run_queue.sv =====
// Top level of the multilevel priority run queue.
//
// Input stream: one transaction per operation; tuser carries the opcode
// (enqueue, dequeue highest, boost all tags, find by id), tdata the thread
// id and the requested priority. Output stream: exactly one transaction per
// operation, in order; tuser carries the status, tdata the id, stored tag
// and level (all zero unless a dequeue or find succeeds).
// A find reads the stored ids level by level, from level 0 upward; the slot
// RAM gives one id a cycle to the single comparator, except while the scan
// steps over to the next level, and the find stops at the first match. Each
// result passes through the one result register on the output: a new
// operation is taken while the last result waits, and the sequencer holds
// the next result until that register frees up.
// Reset clears all levels to empty at once; slot contents need no clearing.
`default_nettype none

module multilevel_priority_run_queue import mprq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] thread_id, [9:8] priority_req, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_thread_id, [9:8] out_priority,
                                     // [11:10] out_level, rest zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  pos_t     head [LEVELS];
  cnt_t     cnt  [LEVELS];
  cnt_t     bst  [LEVELS];
  logic     any;
  lvl_t     top;
  lvl_cmd_t cmd;
  logic     we, re, ready;
  addr_t    waddr, raddr;
  id_t      wdata, rdata;
  logic     res_valid, res_ready;
  result_t  res;
  logic     start;
  lvl_t     req_lvl;
  logic     out_v_q;
  result_t  out_q;

  assign start = s_axis_tvalid && ready;
  assign s_axis_tready = ready;

  // Out-of-range priorities saturate to the top level.
  assign req_lvl = (int'(s_axis_tdata[9:8]) >= LEVELS) ? TOP_LVL : lvl_t'(s_axis_tdata[9:8]);

  mprq_levels u_levels (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .head_o (head),
    .cnt_o  (cnt),
    .bst_o  (bst),
    .any_o  (any),
    .top_o  (top)
  );

  mprq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mprq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (op_e'(s_axis_tuser)),
    .id_i        (id_t'(s_axis_tdata[7:0])),
    .lvl_i       (req_lvl),
    .ready_o     (ready),
    .head_i      (head),
    .cnt_i       (cnt),
    .bst_i       (bst),
    .any_i       (any),
    .top_i       (top),
    .cmd_o       (cmd),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {4'b0000, out_q.level, out_q.prio, out_q.thread_id};

endmodule

`default_nettype wire

// ===== hdl/mprq_checker.sv =====
// Port-level checks of the run queue, bound to the top level.
`default_nettype none

`include "multilevel_priority_run_queue_macros.svh"

module mprq_port_checks import mprq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, s_axis_tuser};

  // One operation at a time: busy right after a transaction is taken.
  `MPRQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Stalled result holds.
  `MPRQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Any failing status carries an all-zero payload.
  `MPRQ_ASSERT_IMP(a_fail_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

  // A stored tag is its own level or the boosted top level, never lower.
  `MPRQ_ASSERT_IMP(a_tag_ge_level, m_axis_tvalid && (m_axis_tuser == ST_OK),
                   m_axis_tdata[9:8] >= m_axis_tdata[11:10])

endmodule

bind multilevel_priority_run_queue mprq_port_checks u_mprq_port_checks (.*);

`default_nettype wire
